>>> sv/rltm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rltm_pkg
// Types and constants shared by the rotor lag thrust and torque mixer.
// ---------------------------------------------------------------------------
package rltm_pkg;

  localparam int LANES       = 4;
  localparam int ROTOR_COUNT = 4;
  localparam int ROT_W       = 2;
  localparam int LANE_W      = 16;

  localparam int REG_COUNT   = 8;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_W       = 64;

  localparam int OUT_FIELDS  = 6;
  localparam int K_W         = 3;

  localparam int MUL_A_W     = 17;
  localparam int MUL_B_W     = 32;
  localparam int PROD_W      = 50;
  localparam int SUM_W       = 51;
  localparam int OUT_W       = 32;

  localparam int NUM_W       = 32;
  localparam int DEN_W       = 18;
  localparam int DIV_STEPS   = 16;
  localparam int DIV_CNT_W   = 4;

  localparam int TDATA_IN_W  = 80;
  localparam int TDATA_OUT_W = 192;

  localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPINUP    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_BASE = 3'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TGT_MUL,
    ST_TGT_CALC,
    ST_PREP,
    ST_STEP_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_SQ_MUL,
    ST_MAC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CFG_W-1:0] max_speed;
    logic [CFG_W-1:0] spinup;
    logic [CFG_W-1:0] coef;
  } cfg_view_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [LANE_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [LANE_W-1:0] lane_of(input logic [CFG_W-1:0] pack,
                                                input logic [ROT_W-1:0] idx);
    return pack[LANE_W*idx +: LANE_W];
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:OUT_W-1] == '0) || (v[SUM_W-1:OUT_W-1] == '1);
    if (fits) begin
      return v[OUT_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/rotor_lag_thrust_torque_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rotor_lag_thrust_torque_mixer
// Four-rotor speed lag and force/torque mix on one shared multiplier.
//
//   Channel   Dir  Contents
//   s_axis    in   duty_zero, duty_one, duty_two, duty_three, step_time
//   m_axis    out  force_x, force_y, force_z, torque_x, torque_y, torque_z
//   cfg       in   eight 64-bit registers, write only
//
// Each rotor in turn takes a target multiply and rounding, a step multiply,
// a wait on the bit-serial division, a speed update, a square and the
// multiply and accumulate over the six coefficients; the result then loads
// once any waiting result is taken, and the input is ready again in idle.
// Reset clears the registers, the rotor speeds and the result valid.
// A waiting result still lets the next item in; a result is held until taken.
// ---------------------------------------------------------------------------
module rotor_lag_thrust_torque_mixer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // duty_zero, duty_one, duty_two, duty_three, step_time
  input  wire logic [rltm_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z
  output logic [rltm_pkg::TDATA_OUT_W-1:0]       m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [rltm_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rltm_pkg::CFG_W-1:0]        cfg_data_i
);
  import rltm_pkg::*;

  state_e state_q, state_d;

  logic [ROT_W-1:0]  rot_q, rot_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [LANE_W-1:0] speed_q [LANES];
  logic              out_valid_q, out_valid_d;

  logic [LANE_W-1:0]       duty_q [LANES];
  logic [LANE_W-1:0]       dt_q;
  logic [LANE_W-1:0]       target_q;
  logic [LANE_W-1:0]       mag_q;
  logic                    up_q;
  logic [DEN_W-1:0]        den_q;
  logic [MUL_B_W-1:0]      w2_q;
  logic signed [SUM_W-1:0] sum_q [OUT_FIELDS];
  logic [OUT_W-1:0]        res_q [OUT_FIELDS];

  cfg_view_t cfg_view;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic in_acc, out_load, rot_last;

  logic [LANE_W:0]   tgt_x_hi;
  logic [LANE_W+1:0] tgt_r1;
  logic [LANE_W:0]   tgt_r2;
  logic [LANE_W-1:0] tgt_val;
  logic [LANE_W-1:0] speed_cur;
  logic [LANE_W-1:0] spinup_cur;
  logic [LANE_W:0]   tau;
  logic              up_now;

  rltm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_sel_i (k_q),
    .view_o     (cfg_view)
  );

  rltm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  rltm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign rot_last      = (rot_q == ROT_W'(ROTOR_COUNT - 1));
  assign speed_cur     = speed_q[rot_q];
  assign spinup_cur    = lane_of(cfg_view.spinup, rot_q);

  // Rounded division by 65535 of duty * max_speed + 32767.
  always_comb begin
    logic [LANE_W:0] x_lo;
    x_lo     = {1'b0, prod[LANE_W-1:0]} + (LANE_W+1)'(16'h7FFF);
    tgt_x_hi = prod[2*LANE_W:LANE_W] + (LANE_W+1)'(x_lo[LANE_W]);
    tgt_r1   = (LANE_W+2)'(x_lo[LANE_W-1:0]) + (LANE_W+2)'(tgt_x_hi);
    tgt_r2   = (LANE_W+1)'(tgt_r1[LANE_W-1:0]) + (LANE_W+1)'(tgt_r1[LANE_W+1:LANE_W]);
    tgt_val  = LANE_W'(tgt_x_hi + (LANE_W+1)'(tgt_r1[LANE_W+1:LANE_W])
                       + (LANE_W+1)'(tgt_r2 >= (LANE_W+1)'(17'h0FFFF)));
  end

  always_comb begin
    up_now = target_q > speed_cur;
    tau    = up_now ? {1'b0, spinup_cur} : {spinup_cur, 1'b0};
    if (tau == '0) begin
      tau = (LANE_W+1)'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (s_axis_tvalid) state_d = ST_TGT_MUL;
      ST_TGT_MUL:   state_d = ST_TGT_CALC;
      ST_TGT_CALC:  state_d = ST_PREP;
      ST_PREP:      state_d = ST_STEP_MUL;
      ST_STEP_MUL:  state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_rsp.done) state_d = ST_UPDATE;
      ST_UPDATE:    state_d = ST_SQ_MUL;
      ST_SQ_MUL:    state_d = ST_MAC;
      ST_MAC: begin
        if (k_q == K_W'(OUT_FIELDS)) begin
          state_d = rot_last ? ST_DONE : ST_TGT_MUL;
        end
      end
      ST_DONE:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = prod[NUM_W-1:0] + NUM_W'(den_q[DEN_W-1:1]);
    div_req.den   = den_q;
    rot_d         = rot_q;
    k_d           = k_q;
    unique case (state_q)
      ST_IDLE: begin
        rot_d = '0;
        k_d   = '0;
      end
      ST_TGT_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, duty_q[rot_q]});
        mul_b  = MUL_B_W'(lane_of(cfg_view.max_speed, rot_q));
      end
      ST_STEP_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, mag_q});
        mul_b  = MUL_B_W'(dt_q);
      end
      ST_DIV_START: div_req.start = 1'b1;
      ST_SQ_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, speed_cur});
        mul_b  = MUL_B_W'(speed_cur);
      end
      ST_MAC: begin
        mul_en = k_q < K_W'(OUT_FIELDS);
        mul_a  = MUL_A_W'($signed(lane_of(cfg_view.coef, rot_q)));
        mul_b  = (k_q == '0) ? prod[MUL_B_W-1:0] : w2_q;
        if (k_q == K_W'(OUT_FIELDS)) begin
          k_d   = '0;
          rot_d = rot_q + 1'b1;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rot_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        speed_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rot_q       <= rot_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_UPDATE) begin
        speed_q[rot_q] <= up_q ? speed_cur + div_rsp.quot : speed_cur - div_rsp.quot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < LANES; i++) begin
        duty_q[i] <= s_axis_tdata[LANE_W*i +: LANE_W];
      end
      dt_q <= s_axis_tdata[LANE_W*LANES +: LANE_W];
      for (int k = 0; k < OUT_FIELDS; k++) begin
        sum_q[k] <= '0;
      end
    end
    if (state_q == ST_TGT_CALC) begin
      target_q <= tgt_val;
    end
    if (state_q == ST_PREP) begin
      up_q  <= up_now;
      mag_q <= up_now ? target_q - speed_cur : speed_cur - target_q;
      den_q <= DEN_W'(tau) + DEN_W'(dt_q);
    end
    if (state_q == ST_MAC) begin
      if (k_q == '0) begin
        w2_q <= prod[MUL_B_W-1:0];
      end else begin
        sum_q[k_q - 1'b1] <= sum_q[k_q - 1'b1] + SUM_W'(prod);
      end
    end
    if (out_load) begin
      for (int k = 0; k < OUT_FIELDS; k++) begin
        res_q[k] <= sat_out(sum_q[k]);
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q[5], res_q[4], res_q[3], res_q[2], res_q[1], res_q[0]};

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("Divider started while busy.");

  a_accept_first_rotor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_TGT_MUL) && (rot_q == '0) && (k_q == '0))
    else $error("Item did not start at the first rotor.");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_WAIT))
    else $error("Division finished outside the wait state.");

endmodule
`default_nettype wire

>>> sv/rltm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rltm_cfg_regs
// Configuration register file with the maximum speed, spin-up and one
// selected coefficient pack presented to the sequencer.
// ---------------------------------------------------------------------------
module rltm_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rltm_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rltm_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic [rltm_pkg::K_W-1:0]       coef_sel_i,
  output rltm_pkg::cfg_view_t                view_o
);
  import rltm_pkg::*;

  logic [CFG_W-1:0]     regs_q [REG_COUNT];
  logic [REG_IDX_W-1:0] coef_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign coef_idx         = REG_COEF_BASE + coef_sel_i;
  assign view_o.max_speed = regs_q[REG_MAX_SPEED];
  assign view_o.spinup    = regs_q[REG_SPINUP];
  assign view_o.coef      = regs_q[coef_idx];

endmodule
`default_nettype wire

>>> sv/rltm_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rltm_mul
// Shared signed by unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module rltm_mul (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic signed [rltm_pkg::MUL_A_W-1:0] a_i,
  input  wire logic [rltm_pkg::MUL_B_W-1:0]        b_i,
  output logic signed [rltm_pkg::PROD_W-1:0]       prod_o
);
  import rltm_pkg::*;

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  assign prod_d = PROD_W'(a_i) * PROD_W'($signed({1'b0, b_i}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

>>> sv/rltm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rltm_div
// Restoring divider, one quotient bit per cycle, for quotients that fit
// in sixteen bits.
// ---------------------------------------------------------------------------
module rltm_div (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  rltm_pkg::div_req_t req_i,
  output rltm_pkg::div_rsp_t rsp_o
);
  import rltm_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [LANE_W-1:0]    lo_q, lo_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign trial = {rem_q, lo_q[LANE_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = DEN_W'(req_i.num[NUM_W-1:LANE_W]);
      lo_d   = req_i.num[LANE_W-1:0];
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_d  = {lo_q[LANE_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = lo_q;

endmodule
`default_nettype wire
